// File: design/cfe_pkg.sv
// shared types, constants and helpers for the crlf command frame extractor
package cfe_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int MAX_FRAMES       = 62;
  localparam int POS_W            = 7;
  localparam int ADDR_W           = 4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    REG_LINK_MODE = 2'd0,
    REG_RATE_CMD  = 2'd1,
    REG_MOTOR_CMD = 2'd2
  } cfe_reg_t;

  typedef struct packed {
    logic       link_mode;
    logic [7:0] rate_cmd;
    logic [7:0] motor_cmd;
  } cfe_cfg_t;

  // one queued operation: store a byte, optionally followed by a line scan
  typedef struct packed {
    logic             scan;
    logic [POS_W-1:0] addr;
    logic [POS_W-1:0] cnt;
    logic [7:0]       data;
  } cfe_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_CHK,
    S_COL_RD,
    S_COL_CHK,
    S_CMD_RD,
    S_CMD_CHK,
    S_PAIR_RD,
    S_PAIR_CHK,
    S_PLAIN_RD,
    S_PLAIN_CHK,
    S_FLUSH
  } cfe_state_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = CH_CR;
      3'd1:    b = CH_LF;
      3'd2:    b = CH_PLUS;
      3'd3:    b = CH_I;
      3'd4:    b = CH_P;
      3'd5:    b = CH_D;
      3'd6:    b = CH_COMMA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/cfe_if.sv
// stream interfaces for received bytes and found frames
interface cfe_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfe_frame_if;
  logic       valid;
  logic       ready;
  logic [5:0] frame_start;
  logic [6:0] frame_length;
  logic       frame_last;
  modport source (output valid, output frame_start, output frame_length,
                  output frame_last, input ready);
  modport sink   (input valid, input frame_start, input frame_length,
                  input frame_last, output ready);
endinterface

// File: design/cfe_front.sv
// front end: counts bytes into the line buffer and spots line ends
module cfe_front
  import cfe_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       link_mode,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output cfe_op_t    q_op
);

  logic [POS_W-1:0] fill_count;
  logic [POS_W-1:0] fill_count_next;
  logic [7:0]       prevb;
  logic [POS_W-1:0] inc;
  logic             line_end;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    inc = fill_count + POS_W'(1);
    if (inc == POS_W'(BUFFER_DEPTH)) inc = '0;
    if (link_mode) line_end = (prevb == CH_LF) && (in_byte == CH_CR);
    else           line_end = (prevb == CH_CR) && (in_byte == CH_LF);
    line_end = line_end && (inc > POS_W'(3));
    q_op.scan = line_end;
    q_op.addr = fill_count;
    q_op.cnt  = inc;
    q_op.data = in_byte;
    fill_count_next = fill_count;
    if (q_push) fill_count_next = line_end ? '0 : inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
    if (q_push) prevb <= in_byte;
  end

endmodule

// File: design/cfe_queue.sv
// two-entry queue of operations between front and back
module cfe_queue
  import cfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cfe_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output cfe_op_t head
);

  cfe_op_t    slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) slots[wp] <= push_op;
  end

endmodule

// File: design/cfe_back.sv
// back end: line buffer memory, line scanner and result register
module cfe_back
  import cfe_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfe_cfg_t    cfg,
  input  logic        q_valid,
  input  cfe_op_t     q_head,
  output logic        q_pop,
  cfe_frame_if.source frame
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata;

  cfe_state_t       state, state_next;
  logic [POS_W-1:0] cnt, cnt_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] start, start_next;
  logic [7:0]       prevb, prevb_next;
  logic [5:0]       nres, nres_next;
  logic             pend_valid, pend_valid_next;
  logic [5:0]       pend_start, pend_start_next;
  logic [6:0]       pend_len, pend_len_next;
  logic             out_valid, out_valid_next;
  logic [5:0]       out_start, out_start_next;
  logic [6:0]       out_len, out_len_next;
  logic             out_last, out_last_next;

  logic             wr_en;
  logic             out_free;
  logic             is_cmd;
  logic             hit;
  logic             rec;
  logic [POS_W-1:0] rec_start;
  logic [POS_W-1:0] rec_len;

  assign out_free           = !out_valid || frame.ready;
  assign is_cmd             = (rdata == cfg.rate_cmd) || (rdata == cfg.motor_cmd);
  assign frame.valid        = out_valid;
  assign frame.frame_start  = out_start;
  assign frame.frame_length = out_len;
  assign frame.frame_last   = out_last;

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_head.addr[AW-1:0]] <= q_head.data;
    rdata <= mem[pos[AW-1:0]];
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    start_next      = start;
    prevb_next      = prevb;
    nres_next       = nres;
    pend_valid_next = pend_valid;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    out_valid_next  = out_valid && !frame.ready;
    out_start_next  = out_start;
    out_len_next    = out_len;
    out_last_next   = out_last;
    q_pop           = 1'b0;
    wr_en           = 1'b0;
    hit             = 1'b0;
    rec             = 1'b0;
    rec_start       = '0;
    rec_len         = '0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          wr_en = 1'b1;
          if (q_head.scan) begin
            cnt_next   = q_head.cnt;
            nres_next  = '0;
            pos_next   = '0;
            state_next = cfg.link_mode ? S_PLAIN_RD : S_HDR_RD;
          end
        end
      end
      S_HDR_RD:  state_next = S_HDR_CHK;
      S_HDR_CHK: begin
        if (rdata != hdr_byte(pos[2:0])) begin
          state_next = S_IDLE;
        end else if (pos == POS_W'(6)) begin
          pos_next   = POS_W'(8);
          state_next = (cnt > POS_W'(8)) ? S_COL_RD : S_IDLE;
        end else begin
          pos_next   = pos + POS_W'(1);
          state_next = S_HDR_RD;
        end
      end
      S_COL_RD:  state_next = S_COL_CHK;
      S_COL_CHK: begin
        pos_next = pos + POS_W'(1);
        if (rdata == CH_COLON) begin
          state_next = (pos + POS_W'(1) < cnt) ? S_CMD_RD : S_FLUSH;
        end else if (pos + POS_W'(1) == cnt) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_COL_RD;
        end
      end
      S_CMD_RD:  state_next = S_CMD_CHK;
      S_CMD_CHK: begin
        pos_next = pos + POS_W'(1);
        if (is_cmd) begin
          // first command byte opens the frame; pairs after it close frames
          start_next = pos;
          prevb_next = rdata;
          state_next = (pos + POS_W'(3) < cnt) ? S_PAIR_RD : S_FLUSH;
        end else begin
          state_next = (pos + POS_W'(1) < cnt) ? S_CMD_RD : S_FLUSH;
        end
      end
      S_PAIR_RD:  state_next = S_PAIR_CHK;
      S_PAIR_CHK: begin
        hit = (prevb == CH_LF) && (rdata == CH_CR);
        if (!(hit && pend_valid && !out_free)) begin
          if (hit) begin
            rec        = 1'b1;
            rec_start  = start;
            rec_len    = pos - start + POS_W'(1);
            start_next = pos + POS_W'(1);
          end
          prevb_next = rdata;
          pos_next   = pos + POS_W'(1);
          state_next = (pos + POS_W'(3) < cnt) ? S_PAIR_RD : S_FLUSH;
        end
      end
      S_PLAIN_RD:  state_next = S_PLAIN_CHK;
      S_PLAIN_CHK: begin
        hit = is_cmd;
        if (!(hit && pend_valid && !out_free)) begin
          if (hit) begin
            rec       = 1'b1;
            rec_start = pos;
            rec_len   = cnt - pos;
          end
          pos_next   = pos + POS_W'(1);
          state_next = (pos + POS_W'(1) < cnt) ? S_PLAIN_RD : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_start_next  = pend_start;
          out_len_next    = pend_len;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // the newest frame waits in pend until we know whether it is the last
    if (rec) begin
      if (pend_valid) begin
        out_valid_next = 1'b1;
        out_start_next = pend_start;
        out_len_next   = pend_len;
        out_last_next  = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_start_next = rec_start[5:0];
      pend_len_next   = rec_len;
      nres_next       = nres + 6'd1;
      if (nres + 6'd1 == 6'(MAX_FRAMES)) state_next = S_FLUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
    cnt        <= cnt_next;
    pos        <= pos_next;
    start      <= start_next;
    prevb      <= prevb_next;
    nres       <= nres_next;
    pend_start <= pend_start_next;
    pend_len   <= pend_len_next;
    out_start  <= out_start_next;
    out_len    <= out_len_next;
    out_last   <= out_last_next;
  end

endmodule

// File: design/crlf_command_frame_extractor.sv
// Command frame extractor: takes received bytes on rx, one word per byte,
// into a line buffer and reports found frames on frame as start offset,
// length and a last-of-line flag. Link mode and the two command byte values
// are set over the APB port (0x0 link_mode, 0x4 rate byte, 0x8 motor byte).
// The front counts bytes and spots the line end; a two-entry operation queue
// feeds the back, which writes the buffer memory and scans lines.
// The back takes ordinary bytes one per cycle, so rx accepts a word every
// cycle while the queue has room. A line end starts a scan through the single
// read port of the buffer, each byte being read in a RD state and then checked
// in a CHK state, with position 7 skipped in header mode. rx stalls once the
// queue fills behind a scan. Each frame leaves through an output register;
// when the receiver holds ready low the scan waits on the next frame found
// and the queue backs up to rx. Reset clears the byte count, the queue, the
// scanner and the registers; buffer contents are not cleared.
module crlf_command_frame_extractor
  import cfe_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cfe_rx_if.sink            rx,
  cfe_frame_if.source       frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfe_cfg_t cfg;
  cfe_reg_t reg_sel;
  cfe_op_t  f_op;
  cfe_op_t  q_head;
  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;

  assign pready  = 1'b1;
  assign reg_sel = cfe_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_LINK_MODE: cfg.link_mode <= pwdata[0];
        REG_RATE_CMD:  cfg.rate_cmd  <= pwdata[7:0];
        REG_MOTOR_CMD: cfg.motor_cmd <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LINK_MODE: prdata = {31'd0, cfg.link_mode};
      REG_RATE_CMD:  prdata = {24'd0, cfg.rate_cmd};
      REG_MOTOR_CMD: prdata = {24'd0, cfg.motor_cmd};
      default:       prdata = '0;
    endcase
  end

  cfe_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .link_mode (cfg.link_mode),
    .in_valid  (rx.valid),
    .in_byte   (rx.rx_byte),
    .in_ready  (rx.ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (f_op)
  );

  cfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (f_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cfe_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .frame   (frame)
  );

endmodule

// File: verif/tb.sv
// testbench for the crlf command frame extractor: directed lines, then random lines
module tb;
  import cfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_LINES = 2;

  typedef struct {
    logic [5:0] start;
    logic [6:0] length;
    logic       last;
  } frame_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cfe_rx_if    rx_ch();
  cfe_frame_if fr_ch();

  crlf_command_frame_extractor u_dut (
    .clk(clk), .rst(rst), .rx(rx_ch), .frame(fr_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [7:0] line_mem [DEPTH];
  int         fill;
  cfe_cfg_t   cfg;
  frame_t     frames_due[$];
  logic [7:0] line_q[$];

  int  errors;
  int  bytes_sent;
  int  frames_seen;
  int  lines_sent;
  int  quiet_cycles;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit is_cmd(input logic [7:0] b);
    return b == cfg.rate_cmd || b == cfg.motor_cmd;
  endfunction

  // store one byte, and on a line end scan the line for frames
  task automatic predict_byte(input logic [7:0] b);
    frame_t found[$];
    frame_t f;
    int     cnt;
    int     i;
    int     j;
    bit     hdr_ok;
    line_mem[fill] = b;
    fill++;
    if (fill == DEPTH) fill = 0;
    cnt = fill;
    if (cnt <= 3) return;
    if (cfg.link_mode) begin
      if (line_mem[cnt-2] == CH_LF && line_mem[cnt-1] == CH_CR) begin
        for (int p = 0; p < cnt; p++)
          if (is_cmd(line_mem[p])) begin
            f.start = p[5:0]; f.length = 7'(cnt - p); f.last = 1'b0;
            found.push_back(f);
          end
        fill = 0;
      end
    end else if (line_mem[cnt-2] == CH_CR && line_mem[cnt-1] == CH_LF) begin
      fill = 0;
      hdr_ok = 1'b1;
      for (int k = 0; k < 7; k++)
        if (line_mem[k] != hdr_byte(3'(k))) hdr_ok = 1'b0;
      if (hdr_ok) begin
        // colon search from position 8; no colon drops the line
        for (i = 8; i < cnt; i++) begin
          if (line_mem[i] == CH_COLON) begin
            i++;
            break;
          end
          if (i + 1 == cnt) hdr_ok = 1'b0;
        end
        if (hdr_ok) begin
          for (; i < cnt; i++) begin
            if (is_cmd(line_mem[i])) begin
              for (j = i + 1; j + 2 < cnt; j++) begin
                if (line_mem[j-1] == CH_LF && line_mem[j] == CH_CR) begin
                  f.start = i[5:0]; f.length = 7'(j - i + 1); f.last = 1'b0;
                  found.push_back(f);
                  i = j + 1;
                end
              end
            end
          end
        end
      end
    end
    while (found.size() > MAX_FRAMES) void'(found.pop_back());
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[n]) frames_due.push_back(found[n]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 24) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[n]) send_byte(line_q[n]);
    lines_sent++;
    line_q.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (frames_due.size() > 0) @(posedge clk);
    // a dropped line may still be scanning
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfe_reg_t r, input logic [7:0] v);
    wait_idle();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = ADDR_W'({r, 2'b00}); pwdata = {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_LINK_MODE: cfg.link_mode = v[0];
      REG_RATE_CMD:  cfg.rate_cmd  = v;
      default:       cfg.motor_cmd = v;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_config(input logic m, input logic [7:0] rate, input logic [7:0] motor);
    write_reg(REG_LINK_MODE, {7'd0, m});
    write_reg(REG_RATE_CMD, rate);
    write_reg(REG_MOTOR_CMD, motor);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR || b == CH_LF || b == CH_COLON);
    return b;
  endfunction

  // header line: CR LF +IPD, filler, colon, then command segments closed by LF CR
  task automatic build_header_line(input int segs, input bit corrupt, input bit colon);
    line_q = {CH_CR, CH_LF, CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};
    if (corrupt) line_q[$urandom_range(6)] = plain_byte();
    repeat ($urandom_range(1, 3)) line_q.push_back(plain_byte());
    if (colon) line_q.push_back(CH_COLON);
    repeat (segs) begin
      line_q.push_back($urandom_range(1) ? cfg.rate_cmd : cfg.motor_cmd);
      repeat ($urandom_range(0, 5)) line_q.push_back(plain_byte());
      line_q.push_back(CH_LF);
      line_q.push_back(CH_CR);
    end
    repeat ($urandom_range(0, 2)) line_q.push_back(plain_byte());
    line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
  endtask

  task automatic build_plain_line(input int len);
    repeat (len) begin
      if ($urandom_range(3) == 0)
        line_q.push_back($urandom_range(1) ? cfg.rate_cmd : cfg.motor_cmd);
      else
        line_q.push_back(plain_byte());
    end
    line_q.push_back(CH_LF);
    line_q.push_back(CH_CR);
  endtask

  task automatic test_header_lines();
    set_config(1'b0, 8'h52, 8'h4D);
    // first line writes the header positions so short lines never read unwritten bytes
    repeat (8) line_q.push_back(8'h41);
    line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
    send_line();
    build_header_line(3, 1'b0, 1'b1);
    send_line();
  endtask

  task automatic test_plain_lines();
    set_config(1'b1, 8'h00, 8'hFF);
    line_q = {8'h00, 8'h11, 8'hFF, 8'h7F, 8'h80, 8'h00};
    build_plain_line(4);
    send_line();
  endtask

  task automatic test_special_cases();
    set_config(1'b0, 8'hFF, 8'h00);
    // bad header, then no colon, then a short line
    build_header_line(1, 1'b1, 1'b1);
    send_line();
    build_header_line(1, 1'b0, 1'b0);
    send_line();
    line_q = {8'h55, 8'h66, CH_CR, CH_LF};
    send_line();
    // buffer full: count wraps, then the next line hits the frame cap since the
    // command bytes equal the line end bytes; neither side idles here
    set_config(1'b1, CH_LF, CH_CR);
    steady = 1'b1;
    repeat (DEPTH) line_q.push_back(plain_byte());
    repeat (61) line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
    line_q.push_back(CH_CR);
    send_line();
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random();
    set_config(1'($urandom), 8'($urandom), 8'($urandom));
    repeat (RANDOM_LINES) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(5, 15)) line_q.push_back(8'($urandom));
        1: build_header_line($urandom_range(1, 3), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        default: begin
          if (cfg.link_mode) build_plain_line($urandom_range(2, 20));
          else build_header_line($urandom_range(1, 4), 1'b0, 1'b1);
        end
      endcase
      send_line();
    end
  endtask

  always @(negedge clk)
    fr_ch.ready <= steady || $urandom_range(99) >= 24;

  always @(posedge clk) begin
    frame_t e;
    if (!rst && fr_ch.valid && fr_ch.ready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame start %0d length %0d",
                                  fr_ch.frame_start, fr_ch.frame_length));
      end else begin
        e = frames_due.pop_front();
        if (fr_ch.frame_start !== e.start)
          report_mismatch($sformatf("frame_start %0d, want %0d", fr_ch.frame_start, e.start));
        if (fr_ch.frame_length !== e.length)
          report_mismatch($sformatf("frame_length %0d, want %0d",
                                    fr_ch.frame_length, e.length));
        if (fr_ch.frame_last !== e.last)
          report_mismatch($sformatf("frame_last %0b, want %0b", fr_ch.frame_last, e.last));
      end
    end
  end

  // watchdog on cycles without any accepted word, accepted frame or register access
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (fr_ch.valid && fr_ch.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress, %0d frames still due", frames_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rx_ch.valid = 1'b0; rx_ch.rx_byte = 8'h00;
    fr_ch.ready = 1'b0;
    fill = 0; cfg = '0; errors = 0; bytes_sent = 0; frames_seen = 0; lines_sent = 0;
    quiet_cycles = 0; steady = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_header_lines();
    test_plain_lines();
    test_special_cases();
    test_random();
    wait_idle();
    $display("sent %0d bytes in %0d lines, checked %0d frames", bytes_sent, lines_sent,
             frames_seen);
    $display("covered both link modes, bad headers, short lines, wrap and frame cap");
    if (errors == 0 && frames_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
